FILE: sv/ggx_pkg.sv
// ----------------------------------------------------------------------------
// GGX microfacet evaluation package
// Item and result types, pipeline record and fixed-point constants.
// ----------------------------------------------------------------------------
package ggx_pkg;

    localparam int DIR_FRAC_BITS = 15;
    localparam int COS_SHIFT     = 2 * DIR_FRAC_BITS - 30;
    localparam int PDF_SHIFT     = 15 + DIR_FRAC_BITS;
    localparam int LAT           = 90;

    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [15:0] ONE_Q15   = 16'h8000;
    localparam logic [30:0] INVPI_Q32 = 31'd1367130551;

    typedef struct packed {
        logic signed [15:0] wo_x;
        logic signed [15:0] wo_y;
        logic signed [15:0] wo_z;
        logic signed [15:0] wi_x;
        logic signed [15:0] wi_y;
        logic signed [15:0] wi_z;
        logic signed [15:0] wh_x;
        logic signed [15:0] wh_y;
        logic signed [15:0] wh_z;
        logic [15:0]        alpha;
    } item_t;

    typedef struct packed {
        logic [31:0] ndf;
        logic [15:0] mask_wo;
        logic [15:0] mask_both;
        logic [31:0] pdf;
        logic        overflow;
    } result_t;

    typedef struct packed {
        item_t               it;
        logic [31:0]         a2;
        logic [30:0]         c2h;
        logic [1:0][30:0]    c2v;
        logic signed [31:0]  po0;
        logic signed [31:0]  po1;
        logic signed [31:0]  po2;
        logic signed [31:0]  pi0;
        logic signed [31:0]  pi1;
        logic signed [31:0]  pi2;
        logic                hz_nz;
        logic [1:0]          z_nz;
        logic [1:0]          z_neg;
        logic [15:0]         oz_abs;
        logic signed [33:0]  voh_o;
        logic signed [33:0]  voh_i;
        logic [30:0]         s2h;
        logic [1:0][30:0]    s2v;
        logic [1:0]          side;
        logic [1:0]          full;
        logic [31:0]         vabs;
        logic [62:0]         a2c2h;
        logic [62:0]         pq;
        logic [1:0][62:0]    a2s2;
        logic [30:0]         t;
        logic [1:0][30:0]    uv;
        logic [61:0]         tt;
        logic [3:0][30:0]    sq_rad;
        logic [3:0][30:0]    sq_root;
        logic [3:0][32:0]    sq_rem;
        logic [61:0]         nd_rem;
        logic [19:0]         nd_lo;
        logic [31:0]         nd_q;
        logic                nd_sat;
        logic                sat_d;
        logic [1:0][31:0]    gd_d;
        logic [1:0][31:0]    gd_rem;
        logic [1:0][15:0]    gd_q;
        logic [1:0][15:0]    g;
        logic [47:0]         w;
        logic                pd_en;
        logic [55:0]         pp_lo;
        logic [55:0]         pp_hi;
        logic [49:0]         mq;
        logic [16:0]         pd_rem;
        logic [31:0]         pd_q;
        logic                pd_sat;
        result_t             res;
    } pipe_t;

endpackage

FILE: sv/ggx_microfacet_eval_core.sv
// ----------------------------------------------------------------------------
// GGX microfacet evaluation core
// Distribution, Smith masking and visible-normal pdf in a 90-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while the output is not stalled; the bit-serial dividers and square roots
// are unrolled into one stage per quotient or root bit.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the stage valid bits only; the data registers are not reset.
module ggx_microfacet_eval_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ggx_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output ggx_pkg::result_t  result
);
    import ggx_pkg::*;

    function automatic logic [30:0] cos2_q30(logic signed [15:0] z);
        logic signed [31:0] p;
        logic [31:0]        q;
        p = 32'(z) * 32'(z);
        q = 32'(p) >> COS_SHIFT;
        if (q > ONE_Q30)
        begin
            q = ONE_Q30;
        end
        return q[30:0];
    endfunction

    function automatic pipe_t stage_fn(pipe_t s_in, int k);
        pipe_t       s;
        logic [61:0] x62;
        logic [34:0] rt;
        logic [34:0] tr;
        logic [62:0] r63;
        logic [31:0] nlo;
        logic [32:0] r33;
        logic [17:0] r18;
        logic [79:0] m;
        int          j;
        s = s_in;
        if (k == 1)
        begin
            s.a2     = 32'(s.it.alpha) * 32'(s.it.alpha);
            s.c2h    = cos2_q30(s.it.wh_z);
            s.c2v[0] = cos2_q30(s.it.wo_z);
            s.c2v[1] = cos2_q30(s.it.wi_z);
            s.po0    = 32'(s.it.wo_x) * 32'(s.it.wh_x);
            s.po1    = 32'(s.it.wo_y) * 32'(s.it.wh_y);
            s.po2    = 32'(s.it.wo_z) * 32'(s.it.wh_z);
            s.pi0    = 32'(s.it.wi_x) * 32'(s.it.wh_x);
            s.pi1    = 32'(s.it.wi_y) * 32'(s.it.wh_y);
            s.pi2    = 32'(s.it.wi_z) * 32'(s.it.wh_z);
            s.hz_nz  = s.it.wh_z != 16'sd0;
            s.z_nz   = {s.it.wi_z != 16'sd0, s.it.wo_z != 16'sd0};
            s.z_neg  = {s.it.wi_z[15], s.it.wo_z[15]};
            s.oz_abs = s.it.wo_z[15] ? 16'(-s.it.wo_z) : 16'(s.it.wo_z);
        end
        if (k == 2)
        begin
            s.voh_o  = 34'(s.po0) + 34'(s.po1) + 34'(s.po2);
            s.voh_i  = 34'(s.pi0) + 34'(s.pi1) + 34'(s.pi2);
            s.s2h    = 31'(ONE_Q30) - s.c2h;
            s.s2v[0] = 31'(ONE_Q30) - s.c2v[0];
            s.s2v[1] = 31'(ONE_Q30) - s.c2v[1];
        end
        if (k == 3)
        begin
            s.side[0] = (s.voh_o != 34'sd0) && s.z_nz[0] && (s.voh_o[33] == s.z_neg[0]);
            s.side[1] = (s.voh_i != 34'sd0) && s.z_nz[1] && (s.voh_i[33] == s.z_neg[1]);
            s.full[0] = s.s2v[0] == 31'd0;
            s.full[1] = s.s2v[1] == 31'd0;
            s.vabs    = s.voh_o[33] ? 32'(-s.voh_o) : 32'(s.voh_o);
            s.a2c2h   = 63'(s.a2) * 63'(s.c2h);
            s.pq      = 63'(s.a2) * 63'(INVPI_Q32);
            s.a2s2[0] = 63'(s.a2) * 63'(s.s2v[0]);
            s.a2s2[1] = 63'(s.a2) * 63'(s.s2v[1]);
        end
        if (k == 4)
        begin
            s.t     = s.a2c2h[62:32] + s.s2h;
            s.uv[0] = s.c2v[0] + s.a2s2[0][62:32];
            s.uv[1] = s.c2v[1] + s.a2s2[1][62:32];
        end
        if (k == 5)
        begin
            s.tt        = 62'(s.t) * 62'(s.t);
            s.sq_rad[0] = s.c2v[0];
            s.sq_rad[1] = s.uv[0];
            s.sq_rad[2] = s.c2v[1];
            s.sq_rad[3] = s.uv[1];
            s.sq_root   = '0;
            s.sq_rem    = '0;
        end
        if (k >= 5 && k <= 35)
        begin
            j = k - 5;
            for (int n = 0; n < 4; n++)
            begin
                x62 = {1'b0, s.sq_rad[n], 30'b0};
                rt  = {s.sq_rem[n], 2'(x62 >> (60 - 2 * j))};
                tr  = {2'b0, s.sq_root[n], 2'b01};
                if (rt >= tr)
                begin
                    s.sq_rem[n]  = 33'(rt - tr);
                    s.sq_root[n] = {s.sq_root[n][29:0], 1'b1};
                end
                else
                begin
                    s.sq_rem[n]  = rt[32:0];
                    s.sq_root[n] = {s.sq_root[n][29:0], 1'b0};
                end
            end
        end
        if (k == 6)
        begin
            s.nd_sat = s.hz_nz && ((s.tt == 62'd0) || ({19'b0, s.pq[62:20]} >= s.tt));
            s.nd_rem = {19'b0, s.pq[62:20]};
            s.nd_lo  = s.pq[19:0];
            s.nd_q   = '0;
        end
        if (k >= 7 && k <= 38)
        begin
            j   = k - 7;
            nlo = {s.nd_lo, 12'b0};
            r63 = {s.nd_rem, 1'(nlo >> (31 - j))};
            if (r63 >= {1'b0, s.tt})
            begin
                r63    = r63 - {1'b0, s.tt};
                s.nd_q = {s.nd_q[30:0], 1'b1};
            end
            else
            begin
                s.nd_q = {s.nd_q[30:0], 1'b0};
            end
            s.nd_rem = r63[61:0];
        end
        if (k == 39)
        begin
            s.res.ndf = !s.hz_nz ? 32'd0 : (s.nd_sat ? '1 : s.nd_q);
            s.sat_d   = s.hz_nz && s.nd_sat;
        end
        if (k == 36)
        begin
            for (int n = 0; n < 2; n++)
            begin
                s.gd_d[n]   = 32'(s.sq_root[2 * n]) + 32'(s.sq_root[2 * n + 1]);
                s.gd_rem[n] = 32'(s.sq_root[2 * n]);
                s.gd_q[n]   = '0;
            end
        end
        if (k >= 37 && k <= 52)
        begin
            for (int n = 0; n < 2; n++)
            begin
                r33 = {s.gd_rem[n], 1'b0};
                if (r33 >= {1'b0, s.gd_d[n]})
                begin
                    r33       = r33 - {1'b0, s.gd_d[n]};
                    s.gd_q[n] = {s.gd_q[n][14:0], 1'b1};
                end
                else
                begin
                    s.gd_q[n] = {s.gd_q[n][14:0], 1'b0};
                end
                s.gd_rem[n] = r33[31:0];
            end
        end
        if (k == 53)
        begin
            for (int n = 0; n < 2; n++)
            begin
                if (!s.side[n])
                begin
                    s.g[n] = '0;
                end
                else if (s.full[n])
                begin
                    s.g[n] = ONE_Q15;
                end
                else if (s.gd_d[n] == 32'd0)
                begin
                    s.g[n] = '0;
                end
                else
                begin
                    s.g[n] = s.gd_q[n];
                end
            end
        end
        if (k == 54)
        begin
            s.w             = 48'(s.g[0]) * 48'(s.vabs);
            s.res.mask_wo   = s.g[0];
            s.res.mask_both = 16'((32'(s.g[0]) * 32'(s.g[1])) >> 15);
            s.pd_en         = s.g[0] != 16'd0;
        end
        if (k == 55)
        begin
            s.pp_lo = 56'(s.res.ndf) * 56'(s.w[23:0]);
            s.pp_hi = 56'(s.res.ndf) * 56'(s.w[47:24]);
        end
        if (k == 56)
        begin
            m    = 80'(s.pp_lo) + (80'(s.pp_hi) << 24);
            s.mq = 50'(m >> PDF_SHIFT);
        end
        if (k == 57)
        begin
            s.pd_sat = s.pd_en && (s.mq[49:32] >= {2'b0, s.oz_abs});
            s.pd_rem = s.mq[48:32];
            s.pd_q   = '0;
        end
        if (k >= 58 && k <= 89)
        begin
            j   = k - 58;
            r18 = {s.pd_rem, 1'(s.mq[31:0] >> (31 - j))};
            if (r18 >= {2'b0, s.oz_abs})
            begin
                r18    = r18 - {2'b0, s.oz_abs};
                s.pd_q = {s.pd_q[30:0], 1'b1};
            end
            else
            begin
                s.pd_q = {s.pd_q[30:0], 1'b0};
            end
            s.pd_rem = r18[16:0];
        end
        if (k == 90)
        begin
            s.res.pdf      = !s.pd_en ? 32'd0 : (s.pd_sat ? '1 : s.pd_q);
            s.res.overflow = s.sat_d || (s.pd_en && s.pd_sat);
        end
        return s;
    endfunction

    pipe_t          st_reg  [1:LAT];
    pipe_t          st_next [1:LAT];
    pipe_t          st_tap  [0:LAT];
    logic [LAT:1]   vld_reg;
    logic           adv;

    assign adv          = !vld_reg[LAT] || result_ready;
    assign item_ready   = adv;
    assign result_valid = vld_reg[LAT];
    assign result       = st_reg[LAT].res;

    always_comb
    begin
        st_tap[0]    = '0;
        st_tap[0].it = item;
    end

    for (genvar k = 1; k <= LAT; k++)
    begin : g_stage
        assign st_tap[k] = st_reg[k];
        always_comb
        begin
            st_next[k] = stage_fn(st_tap[k - 1], k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], item_valid};
        end
    end

endmodule
